// ===== sv/gldp_pkg.sv =====
// gldp_pkg: shared types and constants for the grid longest descent path block.
// Holds the controller state enum, command/status structs and field widths.
// No dependencies.
package gldp_pkg;

    localparam int HEIGHT_W     = 32;
    localparam int LEN_W        = 15;
    localparam int CFG_W        = 8;
    localparam int DIR_W        = 3;
    localparam int DEF_MAX_ROWS = 128;
    localparam int DEF_MAX_COLS = 128;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SCHK,
        ST_STEP,
        ST_NCHK,
        ST_POP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic root_push;
        logic scan_next;
        logic dir_inc;
        logic nb_rd;
        logic push;
        logic fold;
        logic pop;
        logic restore;
        logic root_done;
    } t_cmd;

    typedef struct packed {
        logic load_last;
        logic scan_done;
        logic memo_zero;
        logic dir_done;
        logic nb_valid;
        logic greater;
        logic depth_zero;
    } t_stat;

endpackage

// ===== sv/gldp_ctrl.sv =====
// gldp_ctrl: walk controller for the grid longest descent path block.
// Sequences load, root scan, neighbor probes, push and pop. Depends on gldp_pkg.
module gldp_ctrl import gldp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.load_last) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state = ST_SCHK;
                end
            end
            ST_SCHK: begin
                if (i_stat.memo_zero) begin
                    o_cmd.root_push = 1'b1;
                    n_state = ST_STEP;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_STEP: begin
                if (i_stat.dir_done) begin
                    o_cmd.pop = 1'b1;
                    if (i_stat.depth_zero) begin
                        o_cmd.root_done = 1'b1;
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_POP;
                    end
                end else if (i_stat.nb_valid) begin
                    o_cmd.nb_rd = 1'b1;
                    n_state = ST_NCHK;
                end else begin
                    o_cmd.dir_inc = 1'b1;
                end
            end
            ST_NCHK: begin
                if (i_stat.greater) begin
                    if (i_stat.memo_zero) begin
                        o_cmd.push = 1'b1;
                    end else begin
                        o_cmd.fold = 1'b1;
                    end
                end
                n_state = ST_STEP;
            end
            ST_POP: begin
                o_cmd.restore = 1'b1;
                n_state = ST_STEP;
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_LOAD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== sv/gldp_dpath.sv =====
// gldp_dpath: datapath for the grid longest descent path block.
// Height, memo and walk stack memories, top-of-stack registers, counters.
// Depends on gldp_pkg.
module gldp_dpath import gldp_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int CELLS = MAX_ROWS * MAX_COLS,
    localparam int RCW   = $clog2(MAX_ROWS + 1),
    localparam int CCW   = $clog2(MAX_COLS + 1),
    localparam int CNTW  = $clog2(CELLS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic signed [HEIGHT_W-1:0] i_height,
    input  logic                       i_cfg_wr,
    input  logic [RCW-1:0]             i_rows,
    input  logic [CCW-1:0]             i_cols,
    input  logic [CNTW-1:0]            i_total,
    output logic [LEN_W-1:0]           o_best
);

    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SW = HEIGHT_W + LEN_W + DIR_W + CW + RW + AW;

    logic [HEIGHT_W-1:0] height_mem [CELLS];
    logic [LEN_W-1:0]    memo_mem   [CELLS];
    logic [SW-1:0]       stack_mem  [CELLS];

    logic [CNTW-1:0]            r_load_cnt;
    logic [CNTW-1:0]            r_scan_s;
    logic [RCW-1:0]             r_scan_r;
    logic [CW-1:0]              r_scan_c;
    logic [AW-1:0]              r_top_v;
    logic [RW-1:0]              r_top_r;
    logic [CW-1:0]              r_top_c;
    logic [DIR_W-1:0]           r_top_dir;
    logic [LEN_W-1:0]           r_top_len;
    logic signed [HEIGHT_W-1:0] r_top_h;
    logic [AW-1:0]              r_nb_v;
    logic [RW-1:0]              r_nb_r;
    logic [CW-1:0]              r_nb_c;
    logic [CNTW-1:0]            r_depth;
    logic [LEN_W-1:0]           r_best;
    logic signed [HEIGHT_W-1:0] r_h_rd;
    logic [LEN_W-1:0]           r_memo_rd;
    logic [SW-1:0]              r_stk_rd;

    logic [CNTW-1:0]  load_idx;
    logic             nb_valid;
    logic [AW-1:0]    nb_v;
    logic [RW-1:0]    nb_r;
    logic [CW-1:0]    nb_c;
    logic [AW-1:0]    rd_addr;
    logic [LEN_W-1:0] fold_cand;
    logic [LEN_W-1:0] child_cand;
    logic [HEIGHT_W-1:0] stk_h;
    logic [LEN_W-1:0] stk_len;
    logic [DIR_W-1:0] stk_dir;
    logic [CW-1:0]    stk_c;
    logic [RW-1:0]    stk_r;
    logic [AW-1:0]    stk_v;

    assign load_idx = (r_load_cnt >= i_total) ? '0 : r_load_cnt;

    always_comb begin
        nb_valid = 1'b0;
        nb_v     = r_top_v;
        nb_r     = r_top_r;
        nb_c     = r_top_c;
        case (r_top_dir)
            DIR_LEFT: begin
                nb_valid = (r_top_c != '0);
                nb_v     = r_top_v - AW'(1);
                nb_c     = r_top_c - CW'(1);
            end
            DIR_UP: begin
                nb_valid = (r_top_r != '0);
                nb_v     = r_top_v - AW'(i_cols);
                nb_r     = r_top_r - RW'(1);
            end
            DIR_RIGHT: begin
                nb_valid = ((CCW'(r_top_c) + CCW'(1)) < i_cols);
                nb_v     = r_top_v + AW'(1);
                nb_c     = r_top_c + CW'(1);
            end
            DIR_DOWN: begin
                nb_valid = ((RCW'(r_top_r) + RCW'(1)) < i_rows);
                nb_v     = r_top_v + AW'(i_cols);
                nb_r     = r_top_r + RW'(1);
            end
            default: begin
                nb_valid = 1'b0;
            end
        endcase
    end

    assign rd_addr    = i_cmd.nb_rd ? nb_v : r_scan_s[AW-1:0];
    assign fold_cand  = (r_memo_rd == LEN_MAX) ? LEN_MAX : r_memo_rd + LEN_W'(1);
    assign child_cand = (r_top_len == LEN_MAX) ? LEN_MAX : r_top_len + LEN_W'(1);
    assign {stk_h, stk_len, stk_dir, stk_c, stk_r, stk_v} = r_stk_rd;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            height_mem[load_idx[AW-1:0]] <= i_height;
        end
        if (i_cmd.scan_rd || i_cmd.nb_rd) begin
            r_h_rd <= height_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            memo_mem[load_idx[AW-1:0]] <= '0;
        end else if (i_cmd.pop) begin
            memo_mem[r_top_v] <= r_top_len;
        end
        if (i_cmd.scan_rd || i_cmd.nb_rd) begin
            r_memo_rd <= memo_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            stack_mem[r_depth[AW-1:0]] <=
                {r_top_h, r_top_len, r_top_dir, r_top_c, r_top_r, r_top_v};
        end
        if (i_cmd.pop && (r_depth != '0)) begin
            r_stk_rd <= stack_mem[AW'(r_depth - CNTW'(1))];
        end
    end

    // counters and walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_scan_s   <= '0;
            r_scan_r   <= '0;
            r_scan_c   <= '0;
            r_depth    <= '0;
            r_best     <= '0;
            r_top_dir  <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_load_cnt <= '0;
            end else if (i_cmd.load) begin
                r_load_cnt <= o_stat.load_last ? '0 : load_idx + CNTW'(1);
            end
            if (i_cmd.load && o_stat.load_last) begin
                r_scan_s <= '0;
                r_scan_r <= '0;
                r_scan_c <= '0;
                r_depth  <= '0;
                r_best   <= '0;
            end
            if (i_cmd.scan_next || i_cmd.root_done) begin
                r_scan_s <= r_scan_s + CNTW'(1);
                if ((CCW'(r_scan_c) + CCW'(1)) == i_cols) begin
                    r_scan_c <= '0;
                    r_scan_r <= r_scan_r + RCW'(1);
                end else begin
                    r_scan_c <= r_scan_c + CW'(1);
                end
            end
            if (i_cmd.root_done && (r_top_len > r_best)) begin
                r_best <= r_top_len;
            end
            if (i_cmd.pop && (r_depth != '0)) begin
                r_depth <= r_depth - CNTW'(1);
            end
            if (i_cmd.push && (r_depth < CNTW'(CELLS - 1))) begin
                r_depth <= r_depth + CNTW'(1);
            end
            if (i_cmd.root_push || i_cmd.push) begin
                r_top_dir <= DIR_LEFT;
            end else if (i_cmd.dir_inc || i_cmd.nb_rd) begin
                r_top_dir <= r_top_dir + DIR_W'(1);
            end else if (i_cmd.restore) begin
                r_top_dir <= stk_dir;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.nb_rd) begin
            r_nb_v <= nb_v;
            r_nb_r <= nb_r;
            r_nb_c <= nb_c;
        end
        if (i_cmd.root_push) begin
            r_top_v   <= r_scan_s[AW-1:0];
            r_top_r   <= r_scan_r[RW-1:0];
            r_top_c   <= r_scan_c;
            r_top_h   <= r_h_rd;
            r_top_len <= LEN_W'(1);
        end else if (i_cmd.push) begin
            r_top_v   <= r_nb_v;
            r_top_r   <= r_nb_r;
            r_top_c   <= r_nb_c;
            r_top_h   <= r_h_rd;
            r_top_len <= LEN_W'(1);
        end else if (i_cmd.fold) begin
            if (fold_cand > r_top_len) begin
                r_top_len <= fold_cand;
            end
        end else if (i_cmd.restore) begin
            r_top_v   <= stk_v;
            r_top_r   <= stk_r;
            r_top_c   <= stk_c;
            r_top_h   <= stk_h;
            r_top_len <= (child_cand > stk_len) ? child_cand : stk_len;
        end
    end

    always_comb begin
        o_stat.load_last  = ((load_idx + CNTW'(1)) == i_total);
        o_stat.scan_done  = (r_scan_s == i_total);
        o_stat.memo_zero  = (r_memo_rd == '0);
        o_stat.dir_done   = (r_top_dir == DIR_DONE);
        o_stat.nb_valid   = nb_valid;
        o_stat.greater    = (r_top_h > r_h_rd);
        o_stat.depth_zero = (r_depth == '0);
    end

    assign o_best = r_best;

endmodule

// ===== sv/grid_longest_descent_path.sv =====
// grid_longest_descent_path: top level, APB register file and block wiring.
// Instantiates gldp_ctrl and gldp_dpath; depends on gldp_pkg.
//
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+------------------------
//  input     | start, busy, i_height                    | beat when start & !busy
//  result    | o_valid, o_path_length                   | one-cycle strobe
//  config    | psel penable pwrite paddr pwdata prdata  | APB, pready tied high
//
// Load: one height per cycle, raster order, busy low throughout.
// After the last cell the walk runs with busy high: the root scan passes SCAN and
// SCHK per cell, a direction that leaves the grid is skipped in STEP, a neighbor
// probe passes STEP and NCHK, a pop back to a parent STEP and POP, and a root
// closes in STEP. The result strobes in the cycle after the scan ends.
// Reset is synchronous: row and column counts return to 1, load restarts.
// The receiver cannot stall; each result is valid for exactly one cycle.
module grid_longest_descent_path import gldp_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [HEIGHT_W-1:0] i_height,
    output logic                       o_valid,
    output logic [LEN_W-1:0]           o_path_length,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);
    localparam int CNTW  = $clog2(CELLS + 1);

    logic [CFG_W-1:0] r_rows;
    logic [CFG_W-1:0] r_cols;
    logic             cfg_wr;
    logic [RCW-1:0]   eff_rows;
    logic [CCW-1:0]   eff_cols;
    logic [CNTW-1:0]  total;
    t_cmd             cmd;
    t_stat            stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_W'(1);
            r_cols <= CFG_W'(1);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_ROWS: r_rows <= pwdata[CFG_W-1:0];
                REG_COLS: r_cols <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_COLS) ? 32'(r_cols) : 32'(r_rows);

    always_comb begin
        if (r_rows == '0) begin
            eff_rows = RCW'(1);
        end else if (32'(r_rows) > 32'(MAX_ROWS)) begin
            eff_rows = RCW'(MAX_ROWS);
        end else begin
            eff_rows = RCW'(r_rows);
        end
        if (r_cols == '0) begin
            eff_cols = CCW'(1);
        end else if (32'(r_cols) > 32'(MAX_COLS)) begin
            eff_cols = CCW'(MAX_COLS);
        end else begin
            eff_cols = CCW'(r_cols);
        end
    end

    assign total = CNTW'(CNTW'(eff_rows) * CNTW'(eff_cols));

    gldp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_valid)
    );

    gldp_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_height (i_height),
        .i_cfg_wr (cfg_wr),
        .i_rows   (eff_rows),
        .i_cols   (eff_cols),
        .i_total  (total),
        .o_best   (o_path_length)
    );

endmodule

// ===== bench/grid_longest_descent_path_tb.sv =====
// grid_longest_descent_path_tb: self-checking bench for grid_longest_descent_path.
// Loads height grids over the input channel, predicts the longest descent per grid.
// Depends on gldp_pkg and grid_longest_descent_path.
`timescale 1ns / 1ps

module grid_longest_descent_path_tb;
    import gldp_pkg::*;

    localparam int GRID_ROWS  = DEF_MAX_ROWS;
    localparam int GRID_COLS  = DEF_MAX_COLS;
    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
    localparam int SNAKE_ROWS = 4;
    localparam int CYCLE_CAP  = 8000000;
    localparam logic [2:0] ADDR_ROWS = 3'd0;
    localparam logic [2:0] ADDR_COLS = 3'd4;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [HEIGHT_W-1:0] i_height = '0;
    logic                       o_valid;
    logic [LEN_W-1:0]           o_path_length;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [2:0]                 paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;

    grid_longest_descent_path dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [CFG_W-1:0]           row_reg = 8'd1;
    logic [CFG_W-1:0]           col_reg = 8'd1;
    logic signed [HEIGHT_W-1:0] grid_heights [GRID_CELLS];
    int unsigned                cell_len [GRID_CELLS];
    int unsigned                walk_cells [GRID_CELLS];
    int unsigned                walk_dirs [GRID_CELLS];
    int unsigned                cells_loaded = 0;
    logic [LEN_W-1:0]           pending_lengths [$];
    int                         fail_count = 0;
    int                         burst_left = 0;
    longint                     cycle_count = 0;

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned cap);
        if (v == 0) return 1;
        return (v > cap) ? cap : v;
    endfunction

    function automatic logic [LEN_W-1:0] longest_descent(int unsigned rows,
                                                         int unsigned cols);
        int unsigned total;
        int unsigned top;
        int unsigned cur;
        int unsigned nb;
        int unsigned best;
        int          nr;
        int          nc;
        int          d;
        total = rows * cols;
        best = 0;
        for (int unsigned i = 0; i < total; i++) cell_len[i] = 0;
        for (int unsigned s = 0; s < total; s++) begin
            if (cell_len[s] == 0) begin
                walk_cells[0] = s;
                walk_dirs[0] = 0;
                cell_len[s] = 1;
                top = 1;
                while (top > 0) begin
                    cur = walk_cells[top-1];
                    if (walk_dirs[top-1] < 4) begin
                        d = walk_dirs[top-1];
                        walk_dirs[top-1]++;
                        nr = int'(cur / cols) + ((d == 1) ? -1 : (d == 3) ? 1 : 0);
                        nc = int'(cur % cols) + ((d == 0) ? -1 : (d == 2) ? 1 : 0);
                        if (nr < 0 || nc < 0 || nr >= int'(rows) || nc >= int'(cols))
                            continue;
                        nb = nr * cols + nc;
                        if (!(grid_heights[cur] > grid_heights[nb])) continue;
                        if (cell_len[nb] == 0) begin
                            walk_cells[top] = nb;
                            walk_dirs[top] = 0;
                            cell_len[nb] = 1;
                            top++;
                        end else if (cell_len[nb] + 1 > cell_len[cur]) begin
                            cell_len[cur] = cell_len[nb] + 1;
                        end
                    end else begin
                        top--;
                        if (top > 0 && cell_len[cur] + 1 > cell_len[walk_cells[top-1]])
                            cell_len[walk_cells[top-1]] = cell_len[cur] + 1;
                    end
                end
            end
            if (cell_len[s] > best) best = cell_len[s];
        end
        return (best > 32767) ? LEN_MAX : best[LEN_W-1:0];
    endfunction

    task automatic cfg_write(input logic [2:0] addr, input logic [CFG_W-1:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= {$urandom} & 32'hFFFF_FF00 | 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_ROWS) row_reg = value;
        else col_reg = value;
        cells_loaded = 0;
    endtask

    task automatic send_height(input logic signed [HEIGHT_W-1:0] h, input bit bursty);
        int unsigned rows;
        int unsigned cols;
        if (bursty && burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        start <= 1'b1;
        i_height <= h;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        rows = clamp_dim(row_reg, GRID_ROWS);
        cols = clamp_dim(col_reg, GRID_COLS);
        grid_heights[cells_loaded] = h;
        cells_loaded++;
        if (cells_loaded >= rows * cols) begin
            pending_lengths.push_back(longest_descent(rows, cols));
            cells_loaded = 0;
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_lengths.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic signed [HEIGHT_W-1:0] rand_height();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 3)) - 2;
            default: return $signed($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_lengths.size() == 0) begin
                $error("path_length: unexpected beat, actual %0d", o_path_length);
                fail_count++;
            end else begin
                if (o_path_length !== pending_lengths[0]) begin
                    $error("path_length: expected %0d actual %0d",
                           pending_lengths[0], o_path_length);
                    fail_count++;
                end
                void'(pending_lengths.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("grid_longest_descent_path_tb: errors");
            $finish;
        end
    end

    task automatic test_directed();
        cfg_write(ADDR_ROWS, 8'd0);
        cfg_write(ADDR_COLS, 8'd0);
        send_height(32'sh8000_0000, 1'b0);
        send_height(32'sh7FFF_FFFF, 1'b0);
        send_height(32'sd0, 1'b0);
        send_height(-32'sd1, 1'b0);
        drain();
        cfg_write(ADDR_COLS, 8'd3);
        send_height(32'sh7FFF_FFFF, 1'b0);
        send_height(32'sd0, 1'b0);
        send_height(32'sh8000_0000, 1'b0);
        drain();
        cfg_write(ADDR_ROWS, 8'd2);
        cfg_write(ADDR_COLS, 8'd2);
        repeat (4) send_height(32'sd5, 1'b0);
        // partial load, then restart it with a register write
        send_height(32'sd9, 1'b0);
        send_height(32'sd1, 1'b0);
        start <= 1'b0;
        @(posedge i_clk);
        cfg_write(ADDR_COLS, 8'd2);
        send_height(32'sd4, 1'b0);
        send_height(32'sd3, 1'b0);
        send_height(32'sd1, 1'b0);
        send_height(32'sd2, 1'b0);
        drain();
    endtask

    task automatic test_saturation();
        cfg_write(ADDR_ROWS, 8'd255);
        cfg_write(ADDR_COLS, 8'd1);
        for (int i = 0; i < GRID_ROWS; i++) send_height(rand_height(), 1'b1);
        drain();
        cfg_write(ADDR_ROWS, 8'd1);
        cfg_write(ADDR_COLS, 8'd200);
        for (int i = 0; i < GRID_COLS; i++) send_height(rand_height(), 1'b1);
        drain();
    endtask

    task automatic test_random_grids();
        int unsigned rows;
        int unsigned cols;
        int          sent;
        sent = 0;
        while (sent < 1000) begin
            rows = $urandom_range(1, 8);
            cols = $urandom_range(1, 8);
            cfg_write(ADDR_ROWS, CFG_W'(rows));
            cfg_write(ADDR_COLS, CFG_W'(cols));
            repeat ($urandom_range(1, 4)) begin
                for (int i = 0; i < rows * cols; i++) send_height(rand_height(), 1'b1);
                sent += rows * cols;
            end
            drain();
        end
    endtask

    task automatic test_full_snake();
        cfg_write(ADDR_ROWS, CFG_W'(SNAKE_ROWS));
        cfg_write(ADDR_COLS, CFG_W'(GRID_COLS));
        for (int r = 0; r < SNAKE_ROWS; r++)
            for (int c = 0; c < GRID_COLS; c++)
                send_height(r * GRID_COLS + ((r % 2) ? GRID_COLS - 1 - c : c) - 5000,
                            1'b1);
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_saturation();
        test_random_grids();
        test_full_snake();
        if (fail_count == 0 && pending_lengths.size() == 0) begin
            $display("grid_longest_descent_path_tb: clean");
        end else begin
            $display("grid_longest_descent_path_tb: errors");
        end
        $finish;
    end

endmodule
